@@ rtl/perspective_point_transform_macros.svh @@
// Assertion macros used by the top-level RTL of the perspective point transform.
`ifndef PERSPECTIVE_POINT_TRANSFORM_MACROS_SVH
`define PERSPECTIVE_POINT_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
`define PPT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PPT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/ppt_pkg.sv @@
package ppt_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 8;
   localparam int COEF_WIDTH  = 16;
   localparam int NUM_COLS    = 4;
   localparam int NUM_ROWS    = 4;
   localparam int NUM_LANES   = 3;
   localparam int ROW_WIDTH   = COEF_WIDTH * NUM_COLS;

   localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
   localparam int TRANS_WIDTH = COEF_WIDTH + FRAC_BITS;
   localparam int DOT_WIDTH   = PROD_WIDTH + 2;
   localparam int QBITS       = COORD_WIDTH;
   localparam int NUM_WIDTH   = DOT_WIDTH + FRAC_BITS;
   localparam int CMP_WIDTH   = DOT_WIDTH + QBITS;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_ZERO  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_ONE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_TWO   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_THREE = 3'd3;

   // identity matrix, 1.0 on the diagonal
   localparam logic [ROW_WIDTH-1:0] ROW_ZERO_RESET  = 64'h0000_0000_0000_0100;
   localparam logic [ROW_WIDTH-1:0] ROW_ONE_RESET   = 64'h0000_0000_0100_0000;
   localparam logic [ROW_WIDTH-1:0] ROW_TWO_RESET   = 64'h0000_0100_0000_0000;
   localparam logic [ROW_WIDTH-1:0] ROW_THREE_RESET = 64'h0100_0000_0000_0000;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] in_x;
      logic signed [COORD_WIDTH-1:0] in_y;
      logic signed [COORD_WIDTH-1:0] in_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic                          w_zero;
      logic                          saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] rem;
      logic [DOT_WIDTH-1:0] dvsr;
      logic [QBITS-1:0]     quo;
      logic                 neg;
      logic                 big;
   } div_stage_type;

   typedef struct packed {
      logic [QBITS-1:0] quo;
      logic             neg;
      logic             big;
   } lane_res_type;

endpackage

@@ rtl/perspective_point_transform.sv @@
// A result strobes once its item has passed the two dot-product stages, the divider
// set-up, the 16 quotient-bit stages and the output register.
// Throughput: one item per cycle while busy is low; the divider is fully pipelined, one bit per stage.
// busy is high only while a configuration write is offered on the csr port.
// Synchronous active-high reset clears the pipe's valid bits and the strobe and loads the identity matrix.
`include "perspective_point_transform_macros.svh"
module perspective_point_transform (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  ppt_pkg::req_payload_type                req_data,
   output logic                                    rsp_strobe,
   output ppt_pkg::rsp_payload_type                rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ppt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ppt_pkg::ROW_WIDTH-1:0]           csr_data
);
   import ppt_pkg::*;

   localparam int PIPE_DEPTH = QBITS + 3;
   localparam int WZ_DEPTH   = QBITS + 1;

   logic [ROW_WIDTH-1:0]        row_ff [NUM_ROWS];
   logic [ROW_WIDTH-1:0]        row_in [NUM_ROWS];
   logic signed [DOT_WIDTH-1:0] row_sum [NUM_ROWS];
   lane_res_type                lane_res [NUM_LANES];
   logic [PIPE_DEPTH-1:0]       valid_ff;
   logic [PIPE_DEPTH-1:0]       valid_in;
   logic                        wz_ff [WZ_DEPTH];
   logic                        wz_in [WZ_DEPTH];
   logic                        accept;

   assign busy      = csr_valid;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      row_in = row_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROW_ZERO:  row_in[0] = csr_data;
            REG_ROW_ONE:   row_in[1] = csr_data;
            REG_ROW_TWO:   row_in[2] = csr_data;
            REG_ROW_THREE: row_in[3] = csr_data;
            default:       row_in    = row_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW_ZERO_RESET;
         row_ff[1] <= ROW_ONE_RESET;
         row_ff[2] <= ROW_TWO_RESET;
         row_ff[3] <= ROW_THREE_RESET;
      end else begin
         row_ff <= row_in;
      end
   end

   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_dot
      ppt_dot u_dot (
         .clock (clock),
         .point (req_data),
         .row   (row_ff[r]),
         .sum   (row_sum[r])
      );
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
      ppt_div u_div (
         .clock (clock),
         .num   (row_sum[l]),
         .den   (row_sum[NUM_LANES]),
         .res   (lane_res[l])
      );
   end

   // track items alongside the lanes; w flag joins once w is summed
   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};
      wz_in[0] = (row_sum[NUM_LANES] == '0);
      for (int s = 1; s < WZ_DEPTH; s++) begin
         wz_in[s] = wz_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      wz_ff <= wz_in;
   end

   ppt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .valid      (valid_ff[PIPE_DEPTH-1]),
      .w_zero     (wz_ff[WZ_DEPTH-1]),
      .lane       (lane_res),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `PPT_ASSERT_NEXT(a_accept_enters, clock, reset, accept, valid_ff[0],
                    "accepted item lost")
   `PPT_ASSERT_NEXT(a_strobe_follows, clock, reset, valid_ff[PIPE_DEPTH-1], rsp_strobe,
                    "result lost")
   `PPT_ASSERT_IMPLIES(a_wzero_clean, clock, reset, rsp_strobe && rsp_data.w_zero,
                       !rsp_data.saturated && rsp_data.out_x == '0
                       && rsp_data.out_y == '0 && rsp_data.out_z == '0,
                       "zero w result not cleared")

endmodule

@@ rtl/ppt_dot.sv @@
module ppt_dot (
   input  logic                                     clock,
   input  ppt_pkg::req_payload_type                 point,
   input  logic [ppt_pkg::ROW_WIDTH-1:0]            row,
   output logic signed [ppt_pkg::DOT_WIDTH-1:0]     sum
);
   import ppt_pkg::*;

   logic signed [COEF_WIDTH-1:0]  coef [NUM_COLS];
   logic signed [PROD_WIDTH-1:0]  prod_in [NUM_LANES];
   logic signed [PROD_WIDTH-1:0]  prod_ff [NUM_LANES];
   logic signed [TRANS_WIDTH-1:0] trans_in;
   logic signed [TRANS_WIDTH-1:0] trans_ff;
   logic signed [DOT_WIDTH-1:0]   sum_in;
   logic signed [DOT_WIDTH-1:0]   sum_ff;

   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         coef[c] = $signed(row[c*COEF_WIDTH +: COEF_WIDTH]);
      end
      prod_in[0] = coef[0] * point.in_x;
      prod_in[1] = coef[1] * point.in_y;
      prod_in[2] = coef[2] * point.in_z;
      // scale translation up to the product scale
      trans_in   = $signed({coef[3], {FRAC_BITS{1'b0}}});
      sum_in     = DOT_WIDTH'(prod_ff[0]) + DOT_WIDTH'(prod_ff[1])
                 + DOT_WIDTH'(prod_ff[2]) + DOT_WIDTH'(trans_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      trans_ff <= trans_in;
      sum_ff   <= sum_in;
   end

   assign sum = sum_ff;

endmodule

@@ rtl/ppt_div.sv @@
module ppt_div (
   input  logic                                 clock,
   input  logic signed [ppt_pkg::DOT_WIDTH-1:0] num,
   input  logic signed [ppt_pkg::DOT_WIDTH-1:0] den,
   output ppt_pkg::lane_res_type                res
);
   import ppt_pkg::*;

   div_stage_type stg_in [QBITS+1];
   div_stage_type stg_ff [QBITS+1];

   // one restoring step: try the divisor at bit position idx
   function automatic div_stage_type div_step(div_stage_type s, int unsigned idx);
      logic [CMP_WIDTH-1:0] trial;
      logic [CMP_WIDTH-1:0] rem_w;
      div_stage_type        r;
      r     = s;
      trial = CMP_WIDTH'(s.dvsr) << idx;
      rem_w = CMP_WIDTH'(s.rem);
      if (rem_w >= trial) begin
         r.rem = NUM_WIDTH'(rem_w - trial);
         r.quo = s.quo | (QBITS'(1) << idx);
      end
      return r;
   endfunction

   always_comb begin
      logic [DOT_WIDTH-1:0] n_mag;
      logic [DOT_WIDTH-1:0] d_mag;
      n_mag = num[DOT_WIDTH-1] ? DOT_WIDTH'(-num) : DOT_WIDTH'(num);
      d_mag = den[DOT_WIDTH-1] ? DOT_WIDTH'(-den) : DOT_WIDTH'(den);
      stg_in[0].rem  = {n_mag, {FRAC_BITS{1'b0}}};
      stg_in[0].dvsr = d_mag;
      stg_in[0].quo  = '0;
      stg_in[0].neg  = num[DOT_WIDTH-1] ^ den[DOT_WIDTH-1];
      // quotient that needs more than QBITS bits clamps, unless w is zero
      stg_in[0].big  = CMP_WIDTH'({n_mag, {FRAC_BITS{1'b0}}})
                       >= {d_mag, {QBITS{1'b0}}};
      for (int s = 0; s < QBITS; s++) begin
         stg_in[s+1] = div_step(stg_ff[s], QBITS - 1 - s);
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
   end

   assign res.quo = stg_ff[QBITS].quo;
   assign res.neg = stg_ff[QBITS].neg;
   assign res.big = stg_ff[QBITS].big;

endmodule

@@ rtl/ppt_merge.sv @@
module ppt_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid,
   input  logic                     w_zero,
   input  ppt_pkg::lane_res_type    lane [ppt_pkg::NUM_LANES],
   output logic                     rsp_strobe,
   output ppt_pkg::rsp_payload_type rsp_data
);
   import ppt_pkg::*;

   localparam logic [QBITS-1:0] LIM_POS = {1'b0, {(QBITS-1){1'b1}}};
   localparam logic [QBITS-1:0] LIM_NEG = {1'b1, {(QBITS-1){1'b0}}};

   logic [COORD_WIDTH-1:0] coord [NUM_LANES];
   logic [NUM_LANES-1:0]   lane_sat;
   rsp_payload_type        rsp_data_in;
   rsp_payload_type        rsp_data_ff;
   logic                   rsp_strobe_ff;

   always_comb begin
      logic [QBITS-1:0] lim;
      logic [QBITS-1:0] t;
      for (int l = 0; l < NUM_LANES; l++) begin
         lim         = lane[l].neg ? LIM_NEG : LIM_POS;
         lane_sat[l] = lane[l].big || (lane[l].quo > lim);
         t           = lane_sat[l] ? lim : lane[l].quo;
         coord[l]    = lane[l].neg ? COORD_WIDTH'(-t) : COORD_WIDTH'(t);
      end
      if (w_zero) begin
         rsp_data_in.out_x     = '0;
         rsp_data_in.out_y     = '0;
         rsp_data_in.out_z     = '0;
         rsp_data_in.saturated = 1'b0;
      end else begin
         rsp_data_in.out_x     = $signed(coord[0]);
         rsp_data_in.out_y     = $signed(coord[1]);
         rsp_data_in.out_z     = $signed(coord[2]);
         rsp_data_in.saturated = |lane_sat;
      end
      rsp_data_in.w_zero = w_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
